[rtl/utf8_byte_stream_decoder_assert.svh]
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Clocked assertion wrappers used by the decoder top level; ASSERT_OFF strips them.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define U8D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("utf8 decoder assertion failed");
// cond must never be true outside reset
`define U8D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("utf8 decoder forbidden condition seen");
`else
`define U8D_ASSERT(lbl, prop)
`define U8D_ASSERT_NEVER(lbl, cond)
`endif

`endif

[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Field widths, byte-class constants and the decode step result type.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned UsedW = 3;
  localparam int unsigned RawW  = 32;
  localparam int unsigned HeldW = 24;
  localparam int unsigned CntW  = 2;

  localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo     = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi     = 21'h00DFFF;
  localparam logic [7:0]     ContMask   = 8'hC0;
  localparam logic [7:0]     ContTag    = 8'h80;
  localparam logic [7:0]     Lead2Mask  = 8'hE0;
  localparam logic [7:0]     Lead2Tag   = 8'hC0;
  localparam logic [7:0]     Lead3Mask  = 8'hF0;
  localparam logic [7:0]     Lead3Tag   = 8'hE0;
  localparam logic [7:0]     Lead4Mask  = 8'hF8;
  localparam logic [7:0]     Lead4Tag   = 8'hF0;

  // Outcome of one decode step
  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   code_point;
    logic             is_error;
    logic [UsedW-1:0] bytes_used;
    logic [RawW-1:0]  raw_bytes;
    logic [CntW-1:0]  cnt_nxt;
    logic [HeldW-1:0] held_nxt;
  } u8d_step_t;

endpackage

[rtl/u8d_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder step logic
// Combines one byte with the pending bytes and decides result and next state.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic [7:0]               data_byte,
  input  logic                     end_of_buffer,
  input  logic [u8d_pkg::CntW-1:0] cnt,
  input  logic [u8d_pkg::HeldW-1:0] held,
  output u8d_pkg::u8d_step_t       step
);
  import u8d_pkg::*;

  logic [UsedW-1:0] used;
  logic [RawW-1:0]  raw;
  logic [7:0]       lead;
  logic             is_cont;
  logic [CpW-1:0]   cp2;
  logic [CpW-1:0]   cp3;
  logic [CpW-1:0]   cp4;
  logic             cp4_ok;

  assign used    = {1'b0, cnt} + UsedW'(1);
  assign raw     = {held, data_byte};
  assign is_cont = (data_byte & ContMask) == ContTag;

  always_comb begin
    unique case (cnt)
      2'd0:    lead = data_byte;
      2'd1:    lead = held[7:0];
      2'd2:    lead = held[15:8];
      default: lead = held[23:16];
    endcase
  end

  assign cp2 = CpW'({lead[4:0], data_byte[5:0]});
  assign cp3 = CpW'({lead[3:0], held[5:0], data_byte[5:0]});
  assign cp4 = {lead[2:0], held[13:8], held[5:0], data_byte[5:0]};
  assign cp4_ok = (cp4 <= CpMax) && ((cp4 < SurrLo) || (cp4 > SurrHi));

  always_comb begin
    step            = '0;
    step.bytes_used = used;
    step.raw_bytes  = raw;
    priority if (cnt == 2'd0 && !data_byte[7]) begin
      step.emit       = 1'b1;
      step.code_point = CpW'(data_byte);
    end else if (cnt != 2'd0 && !is_cont) begin
      step.emit     = 1'b1;
      step.is_error = 1'b1;
    end else if (cnt == 2'd1 && (lead & Lead2Mask) == Lead2Tag) begin
      step.emit       = 1'b1;
      step.code_point = cp2;
    end else if (cnt == 2'd2 && (lead & Lead3Mask) == Lead3Tag) begin
      step.emit       = 1'b1;
      step.code_point = cp3;
    end else if (cnt == 2'd3) begin
      step.emit = 1'b1;
      if ((lead & Lead4Mask) == Lead4Tag && cp4_ok) begin
        step.code_point = cp4;
      end else begin
        step.is_error = 1'b1;
      end
    end else if (end_of_buffer) begin
      // sequence cut short: report what was collected
      step.emit     = 1'b1;
      step.is_error = 1'b1;
    end else begin
      // hold the byte and wait for the rest
      step.cnt_nxt  = used[CntW-1:0];
      step.held_nxt = raw[HeldW-1:0];
    end
  end

endmodule

[rtl/utf8_byte_stream_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder
// Byte-at-a-time UTF-8 to code point decoder with error reporting.
// ----------------------------------------------------------------------------
// Accepts one byte per clock cycle while the output is not stalled, with no
// stall of its own. A result for the byte that completes or breaks a
// sequence is decoded while that byte sits in the input register, and the
// result register loads it once the output has room. Up to three bytes
// of an unfinished sequence are held between transfers. Every byte flagged
// as end of buffer produces a result, so no bytes stay pending across
// buffers. Error results carry the raw bytes, first byte in the most
// significant position, and a zero code point.
module utf8_byte_stream_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_end_of_buffer,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [u8d_pkg::CpW-1:0]   out_code_point,
  output logic                      out_is_error,
  output logic [u8d_pkg::UsedW-1:0] out_bytes_used,
  output logic [u8d_pkg::RawW-1:0]  out_raw_bytes
);
  import u8d_pkg::*;

  `include "utf8_byte_stream_decoder_assert.svh"

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_eob_r;
  logic [CntW-1:0]  cnt_r;
  logic [HeldW-1:0] held_r;
  logic             out_valid_r;
  logic [CpW-1:0]   out_cp_r;
  logic             out_err_r;
  logic [UsedW-1:0] out_used_r;
  logic [RawW-1:0]  out_raw_r;
  u8d_step_t        step;
  logic             s1_adv;

  u8d_decode u_decode (
    .data_byte     (s1_byte_r),
    .end_of_buffer (s1_eob_r),
    .cnt           (cnt_r),
    .held          (held_r),
    .step          (step)
  );

  // advance the held byte unless its result would land on a stalled output
  assign s1_adv   = s1_valid_r && (!step.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_eob_r  <= in_end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      held_r <= '0;
    end else if (s1_adv) begin
      cnt_r  <= step.cnt_nxt;
      held_r <= step.held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && step.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step.emit) begin
      out_cp_r   <= step.code_point;
      out_err_r  <= step.is_error;
      out_used_r <= step.bytes_used;
      out_raw_r  <= step.raw_bytes;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_is_error   = out_err_r;
  assign out_bytes_used = out_used_r;
  assign out_raw_bytes  = out_raw_r;

  `U8D_ASSERT(a_err_cp_zero, out_valid_r && out_err_r |-> out_cp_r == '0)
  `U8D_ASSERT(a_eob_flushes, s1_adv && s1_eob_r |=> cnt_r == '0)
  `U8D_ASSERT(a_hold_grows, s1_adv && !step.emit |=> cnt_r == $past(cnt_r) + CntW'(1))
  `U8D_ASSERT(a_s1_kept, s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r))
  `U8D_ASSERT_NEVER(a_used_range, out_valid_r && (out_used_r == '0 || out_used_r > UsedW'(4)))

endmodule

[sim/tb_utf8_byte_stream_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder testbench
// Streams directed and random byte sequences through the decoder with random
// gaps and output stalls, predicts each code point or error result in step
// with the accepted bytes, and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_utf8_byte_stream_decoder;
  import u8d_pkg::*;

  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned LongHold    = 90;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned CycleLimit  = 600000;

  // Known-good and known-bad corner sequences; bit 8 marks end of buffer.
  localparam logic [8:0] Directed [0:29] = '{
    9'h000, 9'h17F,                       // ASCII extremes
    9'h0C0, 9'h080,                       // overlong 2-byte, lowest lead
    9'h0DF, 9'h0BF,                       // highest 2-byte value
    9'h0EF, 9'h0BF, 9'h0BF,               // highest 3-byte value
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,       // highest scalar value
    9'h0F4, 9'h090, 9'h080, 9'h080,       // above the scalar range
    9'h0F0, 9'h08D, 9'h0A0, 9'h080,       // surrogate in 4-byte form
    9'h0C3, 9'h041,                       // broken by a non-continuation
    9'h0E2, 9'h182,                       // buffer ends mid-sequence
    9'h0FF, 9'h080, 9'h080, 9'h080,       // invalid lead collects four
    9'h1C3                                // lead byte alone at end
  };

  typedef struct {
    logic [7:0] data;
    logic       eob;
    bit         wait_idle;
  } in_byte_t;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic             is_error;
    logic [UsedW-1:0] bytes_used;
    logic [RawW-1:0]  raw_bytes;
  } cp_result_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [7:0]          in_data_byte     = '0;
  logic                in_end_of_buffer = 1'b0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [CpW-1:0]      out_code_point;
  logic                out_is_error;
  logic [UsedW-1:0]    out_bytes_used;
  logic [RawW-1:0]     out_raw_bytes;

  in_byte_t    byte_q[$];
  cp_result_t  decoded_q[$];
  int unsigned results_pending = 0;
  int unsigned fail_count      = 0;
  int unsigned bytes_in        = 0;
  int unsigned results_seen    = 0;
  int unsigned invalid_seen    = 0;
  int unsigned four_byte_seen  = 0;
  int unsigned cycle_cnt       = 0;

  // Decoder state as the predictor sees it
  logic [1:0]       seq_len   = '0;
  logic [HeldW-1:0] seq_bytes = '0;

  utf8_byte_stream_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_is_error     (out_is_error),
    .out_bytes_used   (out_bytes_used),
    .out_raw_bytes    (out_raw_bytes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the decoder state by one byte; return 1 when a result is due
  function automatic bit decode_utf8_byte(input logic [7:0] b, input logic eob,
                                          output cp_result_t res);
    logic [UsedW-1:0] used;
    logic [RawW-1:0]  raw;
    logic [7:0]       lead;
    logic [CpW-1:0]   cp;
    bit               done;
    used = {1'b0, seq_len} + 3'd1;
    raw  = {seq_bytes, b};
    case (seq_len)
      2'd1:    lead = seq_bytes[7:0];
      2'd2:    lead = seq_bytes[15:8];
      2'd3:    lead = seq_bytes[23:16];
      default: lead = b;
    endcase
    res  = '0;
    done = 1'b0;
    if (seq_len == 2'd0) begin
      if (!b[7]) begin
        res.code_point = {13'd0, b};
        done = 1'b1;
      end
    end else if ((b & ContMask) != ContTag) begin
      res.is_error = 1'b1;
      done = 1'b1;
    end else if (seq_len == 2'd1 && (lead & Lead2Mask) == Lead2Tag) begin
      res.code_point = {10'd0, lead[4:0], b[5:0]};
      done = 1'b1;
    end else if (seq_len == 2'd2 && (lead & Lead3Mask) == Lead3Tag) begin
      res.code_point = {5'd0, lead[3:0], seq_bytes[5:0], b[5:0]};
      done = 1'b1;
    end else if (seq_len == 2'd3) begin
      cp = {lead[2:0], seq_bytes[13:8], seq_bytes[5:0], b[5:0]};
      if ((lead & Lead4Mask) == Lead4Tag && cp <= CpMax && (cp < SurrLo || cp > SurrHi))
        res.code_point = cp;
      else
        res.is_error = 1'b1;
      done = 1'b1;
    end
    if (!done && eob) begin
      res.is_error = 1'b1;
      done = 1'b1;
    end
    if (done) begin
      res.bytes_used = used;
      res.raw_bytes  = raw;
      seq_len   = '0;
      seq_bytes = '0;
    end else begin
      seq_len   = used[1:0];
      seq_bytes = raw[HeldW-1:0];
    end
    return done;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Byte driver
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_data_byte     <= '0;
      in_end_of_buffer <= 1'b0;
      gap_left         <= 0;
      burst_left       <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (byte_q.size() != 0 &&
                   !(byte_q[0].wait_idle && (in_valid || results_pending != 0))) begin
        in_valid         <= 1'b1;
        in_data_byte     <= byte_q[0].data;
        in_end_of_buffer <= byte_q[0].eob;
        void'(byte_q.pop_front());
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
          gap_left   <= 0;
        end else begin
          gap_left <= pick_gap();
          // now and then run back to back for a while
          if ($urandom_range(0, 39) == 0) burst_left <= $urandom_range(20, 80);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus long holds to back up the input
  int unsigned rdy_left     = 0;
  int unsigned hold_left    = 0;
  int unsigned rx_bytes     = 0;
  int unsigned next_hold_at = 300;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rdy_left     <= 0;
      hold_left    <= 0;
      rx_bytes     <= 0;
      next_hold_at <= 300;
    end else begin
      rx_bytes <= rx_bytes + ((in_valid && in_ready) ? 1 : 0);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (rx_bytes >= next_hold_at) begin
        out_ready    <= 1'b0;
        hold_left    <= LongHold;
        next_hold_at <= next_hold_at + 700;
      end else if (rdy_left != 0) begin
        rdy_left <= rdy_left - 1;
      end else if (out_ready) begin
        out_ready <= 1'b0;
        rdy_left  <= pick_gap();
      end else begin
        out_ready <= 1'b1;
        rdy_left  <= $urandom_range(0, 30);
      end
    end
  end

  // Predict on each accepted byte, then check each accepted result
  always @(posedge clk) begin : mon
    cp_result_t want;
    cp_result_t got;
    if (!rst_n) begin
      seq_len   = '0;
      seq_bytes = '0;
      results_pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_in++;
        if (decode_utf8_byte(in_data_byte, in_end_of_buffer, want))
          decoded_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{out_code_point, out_is_error, out_bytes_used, out_raw_bytes};
        results_seen++;
        if (got.is_error) invalid_seen++;
        else if (got.bytes_used == 3'd4) four_byte_seen++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cp 0x%0h err %0b used %0d raw 0x%0h",
                   $time, got.code_point, got.is_error, got.bytes_used, got.raw_bytes);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(got.code_point));
          check_field("is_error",   32'(want.is_error),   32'(got.is_error));
          check_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
          check_field("raw_bytes",  want.raw_bytes,       got.raw_bytes);
        end
      end
      results_pending <= decoded_q.size();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, decoded_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  seq[$];
    logic [7:0]  b;
    int unsigned kind;
    int unsigned len;
    int unsigned n_rand;
    bit          mid_drain;
    bit          eob;

    foreach (Directed[i])
      byte_q.push_back('{data: Directed[i][7:0], eob: Directed[i][8], wait_idle: 1'b0});

    n_rand    = 0;
    mid_drain = 1'b0;
    while (n_rand < RandomBytes) begin
      seq.delete();
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      if (kind < 7) begin
        // well-formed sequence with random content, now and then a surrogate or an out-of-range lead
        case (len)
          1: seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
          2: seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          3: seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              // surrogate range in 4-byte form
              seq.push_back(8'hF0);
              seq.push_back(8'h8D);
              len = 2;
            end else begin
              seq.push_back(8'($urandom_range(0, 9) == 0 ? $urandom_range(8'hF5, 8'hF7)
                                                          : $urandom_range(8'hF0, 8'hF4)));
            end
          end
        endcase
        while (seq.size() < 4 && (seq.size() < len || (seq[0] == 8'hF0 && seq.size() < 4
                                                      && seq[1] == 8'h8D))) begin
          if (seq.size() == 2 && seq[0] == 8'hF0 && seq[1] == 8'h8D)
            seq.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          else
            seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      end else if (kind == 7) begin
        // raw noise, invalid leads included
        repeat (len) seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        // truncated sequence, broken by a foreign byte or by end of buffer
        seq.push_back(8'($urandom_range(0, 2) == 0 ? $urandom_range(8'hC0, 8'hDF)
                    : ($urandom_range(0, 1) ? $urandom_range(8'hE0, 8'hEF)
                                            : $urandom_range(8'hF0, 8'hF4))));
        repeat ($urandom_range(0, 1)) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        if (kind == 8) begin
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          seq.push_back(b);
        end
      end
      foreach (seq[i]) begin
        if (kind == 9)       eob = (i == seq.size() - 1);
        else if (kind == 7)  eob = ($urandom_range(0, 5) == 0);
        else                 eob = (i == seq.size() - 1) && ($urandom_range(0, 7) == 0);
        byte_q.push_back('{data: seq[i], eob: eob,
                           wait_idle: (n_rand == 0) || (n_rand >= 800 && !mid_drain)});
        if (n_rand >= 800) mid_drain = 1'b1;
        n_rand++;
      end
    end
    byte_q[byte_q.size() - 1].eob = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (byte_q.size() != 0 || in_valid);
    do @(negedge clk); while (decoded_q.size() != 0);
    repeat (TailCycles) @(negedge clk);

    $display("Streamed %0d bytes into %0d results: %0d invalid, %0d four-byte scalars,",
             bytes_in, results_seen, invalid_seen, four_byte_seen);
    $display("with random gaps, two long output holds and two drain pauses.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
